/* src/pbr_pkg.sv */
`timescale 1ns / 1ps
// pbr_pkg: widths, gain and arctangent constants, pipeline word type and
// register indexes for point_bearing_and_range; depends on nothing
package pbr_pkg;

	localparam int COORD_WIDTH   = 32;
	localparam int ANGLE_WIDTH   = 16;
	localparam int CORDIC_STAGES = 16;
	localparam int GUARD_BITS    = 8;

	// dx/dy width, datapath width with guard bits and cordic growth headroom
	localparam int DELTA_W = COORD_WIDTH + 1;
	localparam int XW      = COORD_WIDTH + GUARD_BITS + 4;
	localparam int IDX_W   = (CORDIC_STAGES > 1) ? $clog2(CORDIC_STAGES) : 1;

	// gain multiply split: low 32 bits and the rest of the magnitude
	localparam int UX_W  = XW - 1;
	localparam int HI_W  = (UX_W > 32) ? UX_W - 32 : 1;
	localparam int UXE_W = 32 + HI_W;
	localparam int PW    = HI_W + 33;
	localparam int RW    = PW + 1;
	localparam int DIST_W = RW - GUARD_BITS;

	localparam logic [63:0] KINF_Q32  = 64'd2608131496;
	localparam logic [63:0] KCORR_Q32 = 64'd1738754331;
	localparam logic [63:0] KGAIN_64  = KINF_Q32 +
		((2 * CORDIC_STAGES < 40) ? (KCORR_Q32 >> (2 * CORDIC_STAGES)) : 64'd0);
	localparam logic [31:0] KGAIN     = KGAIN_64[31:0];

	localparam logic [31:0] QUARTER_TURN = 32'h4000_0000;
	localparam logic [31:0] HALF_TURN    = 32'h8000_0000;

	localparam logic [31:0] ATAN_TURNS [32] = '{
		32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
		32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
		32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
		32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
		32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
		32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
		32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
		32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
	};

	localparam int CFG_IDX_W = 2;
	localparam int CFG_DW    = COORD_WIDTH;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_VIEWER_X       = 2'd0,
		REG_VIEWER_Y       = 2'd1,
		REG_VIEWER_HEADING = 2'd2,
		REG_UNUSED         = 2'd3
	} cfg_reg_t;

	typedef struct packed {
		logic               nz;
		logic signed [XW-1:0] x;
		logic signed [XW-1:0] y;
		logic [31:0]        z;
	} cordic_word_t;

	function automatic logic [31:0] atan_turn(input logic [4:0] i);
		return ATAN_TURNS[i];
	endfunction

endpackage

/* src/pbr_delta.sv */
`timescale 1ns / 1ps
// pbr_delta: offset from viewer and left half plane pre-rotation, two stages
// depends on pbr_pkg
module pbr_delta import pbr_pkg::*; (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic signed [COORD_WIDTH-1:0] px,
	input  logic signed [COORD_WIDTH-1:0] py,
	input  logic signed [COORD_WIDTH-1:0] vx,
	input  logic signed [COORD_WIDTH-1:0] vy,
	output logic                          out_valid,
	input  logic                          out_ready,
	output cordic_word_t                  out_word
);

	logic                       v_s1, v_s2;
	logic signed [DELTA_W-1:0]  dx_s1, dy_s1;
	cordic_word_t               word_s2;
	logic                       rdy_s1;
	logic signed [XW-1:0]       x_ext, y_ext, x_rot, y_rot;

	assign rdy_s1   = !v_s2 || out_ready;
	assign in_ready = !v_s1 || rdy_s1;

	always_comb begin
		x_ext = XW'(dx_s1);
		y_ext = XW'(dy_s1);
		x_rot = dx_s1[DELTA_W-1] ? -x_ext : x_ext;
		y_rot = dx_s1[DELTA_W-1] ? -y_ext : y_ext;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (in_ready) v_s1 <= in_valid;
			if (rdy_s1)   v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			dx_s1 <= DELTA_W'(px) - DELTA_W'(vx);
			dy_s1 <= DELTA_W'(py) - DELTA_W'(vy);
		end
		if (v_s1 && rdy_s1) begin
			word_s2.nz <= (dx_s1 != '0) || (dy_s1 != '0);
			word_s2.x  <= x_rot <<< GUARD_BITS;
			word_s2.y  <= y_rot <<< GUARD_BITS;
			word_s2.z  <= dx_s1[DELTA_W-1] ? HALF_TURN : 32'd0;
		end
	end

	assign out_valid = v_s2;
	assign out_word  = word_s2;

endmodule

/* src/pbr_cordic_stage.sv */
`timescale 1ns / 1ps
// pbr_cordic_stage: one registered vectoring micro-rotation
// depends on pbr_pkg
module pbr_cordic_stage import pbr_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [IDX_W-1:0] idx,
	input  logic             in_valid,
	output logic             in_ready,
	input  cordic_word_t     in_word,
	output logic             out_valid,
	input  logic             out_ready,
	output cordic_word_t     out_word
);

	logic                 v_s1;
	cordic_word_t         word_s1;
	logic signed [XW-1:0] xs, ys;
	logic [31:0]          ang;
	cordic_word_t         nxt;

	assign in_ready = !v_s1 || out_ready;

	always_comb begin
		xs     = in_word.x >>> idx;
		ys     = in_word.y >>> idx;
		ang    = atan_turn(5'(idx));
		nxt.nz = in_word.nz;
		if (!in_word.y[XW-1]) begin
			nxt.x = in_word.x + ys;
			nxt.y = in_word.y - xs;
			nxt.z = in_word.z + ang;
		end else begin
			nxt.x = in_word.x - ys;
			nxt.y = in_word.y + xs;
			nxt.z = in_word.z - ang;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_ready) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) word_s1 <= nxt;
	end

	assign out_valid = v_s1;
	assign out_word  = word_s1;

endmodule

/* src/pbr_scale.sv */
`timescale 1ns / 1ps
// pbr_scale: gain correction, rounding, saturation and bearing, two stages
// depends on pbr_pkg
module pbr_scale import pbr_pkg::*; (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [ANGLE_WIDTH-1:0]        heading,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  cordic_word_t                  in_word,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic signed [ANGLE_WIDTH-1:0] bearing,
	output logic [DELTA_W-1:0]            distance
);

	logic                  v_s1, v_s2, rdy_s1;
	logic [PW-1:0]         phi_s1;
	logic [31:0]           plo_s1;
	logic [31:0]           z_s1;
	logic                  nz_s1;
	logic [UX_W-1:0]       ux;
	logic [UXE_W-1:0]      ux_ext;
	logic [63:0]           lo_prod;
	logic [PW-1:0]         prod;
	logic [RW-1:0]         rsum;
	logic [DIST_W-1:0]     dist_rnd;
	logic [DELTA_W-1:0]    dist_sat;
	logic [31:0]           zf, b32, bsum;
	logic [ANGLE_WIDTH-1:0] bearing_s2;
	logic [DELTA_W-1:0]    dist_s2;

	assign rdy_s1   = !v_s2 || out_ready;
	assign in_ready = !v_s1 || rdy_s1;

	always_comb begin
		ux      = in_word.x[XW-1] ? '0 : in_word.x[UX_W-1:0];
		ux_ext  = UXE_W'(ux);
		lo_prod = 64'(ux_ext[31:0]) * 64'(KGAIN);
	end

	always_comb begin
		prod     = phi_s1 + PW'(plo_s1);
		rsum     = RW'(prod) + RW'(1 << (GUARD_BITS - 1));
		dist_rnd = rsum[RW-1:GUARD_BITS];
		dist_sat = (|dist_rnd[DIST_W-1:DELTA_W]) ? '1 : dist_rnd[DELTA_W-1:0];
		zf       = nz_s1 ? z_s1 : 32'd0;
		b32      = QUARTER_TURN - {heading, (32-ANGLE_WIDTH)'(0)} - zf;
		bsum     = b32 + (32'd1 << (31 - ANGLE_WIDTH));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (in_ready) v_s1 <= in_valid;
			if (rdy_s1)   v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			phi_s1 <= PW'(ux_ext[UXE_W-1:32]) * PW'(KGAIN);
			plo_s1 <= lo_prod[63:32];
			z_s1   <= in_word.z;
			nz_s1  <= in_word.nz;
		end
		if (v_s1 && rdy_s1) begin
			bearing_s2 <= bsum[31 -: ANGLE_WIDTH];
			dist_s2    <= nz_s1 ? dist_sat : '0;
		end
	end

	assign out_valid = v_s2;
	assign bearing   = signed'(bearing_s2);
	assign distance  = dist_s2;

endmodule

/* src/point_bearing_and_range.sv */
`timescale 1ns / 1ps
// point_bearing_and_range: top level, viewer registers and pipeline chain
// depends on pbr_pkg, pbr_delta, pbr_cordic_stage, pbr_scale
//
// usage
// - cfg channel: cfg_index selects viewer_x, viewer_y or viewer_heading,
//   cfg_data carries the value; always ready; the user must write it only while idle, the block does not enforce it
// - point channel: one word of point_x, point_y per accepted handshake
// - result channel: one word of bearing, ground_distance per point, in order
// - pipeline: one point per cycle sustained while results are taken, one
//   pipeline stage per micro-rotation plus two offset stages and two scaling
//   stages, registered in that order between the point accept and the result
// - each stage holds its word while the next is full, so a stalled result
//   stops nothing upstream until the bubbles ahead of it are filled
// - reset clears all valid bits and the viewer registers to zero
module point_bearing_and_range import pbr_pkg::*; (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [CFG_IDX_W-1:0]          cfg_index,
	input  logic [CFG_DW-1:0]             cfg_data,
	input  logic                          point_valid,
	output logic                          point_ready,
	input  logic signed [COORD_WIDTH-1:0] point_x,
	input  logic signed [COORD_WIDTH-1:0] point_y,
	output logic                          result_valid,
	input  logic                          result_ready,
	output logic signed [ANGLE_WIDTH-1:0] bearing,
	output logic [DELTA_W-1:0]            ground_distance
);

	logic signed [COORD_WIDTH-1:0] viewer_x_q, viewer_y_q;
	logic [ANGLE_WIDTH-1:0]        viewer_heading_q;

	logic         chain_valid [CORDIC_STAGES+1];
	logic         chain_ready [CORDIC_STAGES+1];
	cordic_word_t chain_word  [CORDIC_STAGES+1];

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			viewer_x_q       <= '0;
			viewer_y_q       <= '0;
			viewer_heading_q <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_VIEWER_X:       viewer_x_q <= signed'(cfg_data[COORD_WIDTH-1:0]);
				REG_VIEWER_Y:       viewer_y_q <= signed'(cfg_data[COORD_WIDTH-1:0]);
				REG_VIEWER_HEADING: viewer_heading_q <= cfg_data[ANGLE_WIDTH-1:0];
				default: ;
			endcase
		end
	end

	pbr_delta u_delta (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (point_valid),
		.in_ready  (point_ready),
		.px        (point_x),
		.py        (point_y),
		.vx        (viewer_x_q),
		.vy        (viewer_y_q),
		.out_valid (chain_valid[0]),
		.out_ready (chain_ready[0]),
		.out_word  (chain_word[0])
	);

	for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_stage
		pbr_cordic_stage u_stage (
			.clk       (clk),
			.arst_n    (arst_n),
			.idx       (IDX_W'(g)),
			.in_valid  (chain_valid[g]),
			.in_ready  (chain_ready[g]),
			.in_word   (chain_word[g]),
			.out_valid (chain_valid[g+1]),
			.out_ready (chain_ready[g+1]),
			.out_word  (chain_word[g+1])
		);
	end

	pbr_scale u_scale (
		.clk       (clk),
		.arst_n    (arst_n),
		.heading   (viewer_heading_q),
		.in_valid  (chain_valid[CORDIC_STAGES]),
		.in_ready  (chain_ready[CORDIC_STAGES]),
		.in_word   (chain_word[CORDIC_STAGES]),
		.out_valid (result_valid),
		.out_ready (result_ready),
		.bearing   (bearing),
		.distance  (ground_distance)
	);

endmodule
